>>> design/uppercase_overstrike_filter_macros.svh
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef UPPERCASE_OVERSTRIKE_FILTER_MACROS_SVH
`define UPPERCASE_OVERSTRIKE_FILTER_MACROS_SVH

`define UOF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define UOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/uof_pkg.sv
package uof_pkg;

  localparam int LINE_MAX   = 256;
  localparam int LINE_AW    = $clog2(LINE_MAX);
  localparam int LEN_W      = $clog2(LINE_MAX + 1);
  localparam int MAX_REPEAT = 9;
  localparam int REP_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_BUSY      = 2'd1,
    ST_NOT_ASCII = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_PULL,
    CMD_BAD,
    CMD_NL,
    CMD_FF,
    CMD_CHAR
  } cmd_e;

  // where the output byte comes from
  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_RAW,
    SRC_MASK
  } src_e;

  typedef struct packed {
    cmd_e       kind;
    logic [6:0] ch;
    logic       upper;
  } cmd_t;

  function automatic logic is_upper(input logic [6:0] c);
    return (c >= 7'h41) && (c <= 7'h5A);
  endfunction

  function automatic logic is_print(input logic [6:0] c);
    return (c >= 7'h20) && (c <= 7'h7E);
  endfunction

endpackage

>>> design/uof_front.sv
module uof_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [7:0]      in_byte_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output uof_pkg::cmd_t   cmd_o
);

  uof_pkg::cmd_t                   queue_q [uof_pkg::QUEUE_DEPTH];
  logic [uof_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [uof_pkg::QUEUE_AW:0]      count_q, count_d;
  uof_pkg::cmd_t                   cls;
  logic                            push, pop;

  // classify the incoming beat
  always_comb begin
    cls.ch    = in_byte_i[6:0];
    cls.upper = uof_pkg::is_upper(in_byte_i[6:0]);
    priority if (req_type_i)             cls.kind = uof_pkg::CMD_PULL;
    else if (in_byte_i[7])               cls.kind = uof_pkg::CMD_BAD;
    else if (in_byte_i == uof_pkg::CH_NL) cls.kind = uof_pkg::CMD_NL;
    else if (in_byte_i == uof_pkg::CH_FF) cls.kind = uof_pkg::CMD_FF;
    else                                 cls.kind = uof_pkg::CMD_CHAR;
  end

  assign in_ready_o  = (count_q != (uof_pkg::QUEUE_AW+1)'(uof_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (uof_pkg::QUEUE_AW+1)'(push) - (uof_pkg::QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> design/uof_back.sv
module uof_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [uof_pkg::REP_W-1:0] repeat_i,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  uof_pkg::cmd_t             cmd_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output uof_pkg::status_e          out_status_o,
  output logic                      out_eol_o
);

  logic [6:0]                 line_store_q [uof_pkg::LINE_MAX];
  logic [6:0]                 rd_data_q;

  logic [uof_pkg::LEN_W-1:0]  len_q, len_d, pos_q, pos_d;
  logic [uof_pkg::REP_W-1:0]  pass_q, pass_d, rep_eff;
  logic                       upper_q, upper_d, emit_q, emit_d, err_q, err_d;

  // result stage
  logic                       res_valid_q, res_valid_d, res_eol_q, res_eol_d;
  uof_pkg::src_e              res_src_q, res_src_d;
  logic [7:0]                 res_byte_q, res_byte_d;
  uof_pkg::status_e           res_status_q, res_status_d;

  logic                       pop, wr_en, rd_en, keep;

  assign cmd_ready_o = !res_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign rep_eff     = (repeat_i > uof_pkg::REP_W'(uof_pkg::MAX_REPEAT))
                     ? uof_pkg::REP_W'(uof_pkg::MAX_REPEAT) : repeat_i;

  always_comb begin
    len_d        = len_q;
    pos_d        = pos_q;
    pass_d       = pass_q;
    upper_d      = upper_q;
    emit_d       = emit_q;
    err_d        = err_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    res_valid_d  = res_valid_q && !out_ready_i;
    res_src_d    = res_src_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    res_eol_d    = res_eol_q;
    if (pop) begin
      res_valid_d  = 1'b1;
      res_src_d    = uof_pkg::SRC_CONST;
      res_byte_d   = 8'h00;
      res_status_d = uof_pkg::ST_DATA;
      res_eol_d    = 1'b0;
      if (err_q) begin
        res_status_d = uof_pkg::ST_NOT_ASCII;
      end else begin
        unique case (cmd_i.kind)
          uof_pkg::CMD_PULL: begin
            if (!emit_q) begin
              res_valid_d = 1'b0;
            end else if (upper_q && (pass_q < rep_eff)) begin
              if (pos_q < len_q) begin
                rd_en     = 1'b1;
                pos_d     = pos_q + 1'b1;
                res_src_d = uof_pkg::SRC_MASK;
              end else begin
                pos_d      = '0;
                pass_d     = pass_q + 1'b1;
                res_byte_d = uof_pkg::CH_CR;
              end
            end else if (pos_q < len_q) begin
              rd_en     = 1'b1;
              pos_d     = pos_q + 1'b1;
              res_src_d = uof_pkg::SRC_RAW;
            end else if (upper_q && (pos_q == len_q)) begin
              pos_d      = pos_q + 1'b1;
              res_byte_d = uof_pkg::CH_CR;
            end else begin
              emit_d     = 1'b0;
              len_d      = '0;
              upper_d    = 1'b0;
              pass_d     = '0;
              pos_d      = '0;
              res_byte_d = uof_pkg::CH_NL;
              res_eol_d  = 1'b1;
            end
          end
          uof_pkg::CMD_BAD: begin
            err_d        = 1'b1;
            res_status_d = uof_pkg::ST_NOT_ASCII;
          end
          uof_pkg::CMD_NL: begin
            if (emit_q) begin
              res_status_d = uof_pkg::ST_BUSY;
            end else begin
              emit_d      = 1'b1;
              pass_d      = '0;
              pos_d       = '0;
              res_valid_d = 1'b0;
            end
          end
          uof_pkg::CMD_FF: begin
            if (emit_q) res_status_d = uof_pkg::ST_BUSY;
            else        res_byte_d   = uof_pkg::CH_FF;
          end
          uof_pkg::CMD_CHAR: begin
            if (emit_q) begin
              res_status_d = uof_pkg::ST_BUSY;
            end else if (len_q >= uof_pkg::LEN_W'(uof_pkg::LINE_MAX)) begin
              res_status_d = uof_pkg::ST_OVERFLOW;
            end else begin
              wr_en       = 1'b1;
              len_d       = len_q + 1'b1;
              upper_d     = upper_q || cmd_i.upper;
              res_valid_d = 1'b0;
            end
          end
          default: res_status_d = uof_pkg::ST_NOT_ASCII;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_store_q[len_q[uof_pkg::LINE_AW-1:0]] <= cmd_i.ch;
    end
    if (rd_en) begin
      rd_data_q <= line_store_q[pos_q[uof_pkg::LINE_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pos_q       <= '0;
      pass_q      <= '0;
      upper_q     <= 1'b0;
      emit_q      <= 1'b0;
      err_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      pos_q       <= pos_d;
      pass_q      <= pass_d;
      upper_q     <= upper_d;
      emit_q      <= emit_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_src_q    <= res_src_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    res_eol_q    <= res_eol_d;
  end

  // overprint pass keeps capitals and control bytes, blanks the rest
  assign keep = uof_pkg::is_upper(rd_data_q) || !uof_pkg::is_print(rd_data_q);

  always_comb begin
    unique case (res_src_q)
      uof_pkg::SRC_RAW:  out_byte_o = {1'b0, rd_data_q};
      uof_pkg::SRC_MASK: out_byte_o = keep ? {1'b0, rd_data_q} : uof_pkg::CH_SP;
      default:           out_byte_o = res_byte_q;
    endcase
  end

  assign out_valid_o  = res_valid_q;
  assign out_status_o = res_status_q;
  assign out_eol_o    = res_eol_q;

endmodule

>>> design/uppercase_overstrike_filter.sv
// Flow: a beat accepted is written into the command queue; the executor takes it from there
//   when ready, and its answer, if any, is registered in the result stage for the master side.
// Throughput: one beat per cycle while the master side accepts; the line store is touched at most once a beat.
// Reset (async, active low) clears the queue, line state, error flag and repeat count;
//   the line store is not cleared and is read only below the current line length.
`include "uppercase_overstrike_filter_macros.svh"

module uppercase_overstrike_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] in_byte
  input  logic                      s_axis_tuser,  // [0] req_type
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]                m_axis_tuser,  // [1:0] status
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [uof_pkg::REP_W-1:0] cfg_data_i
);

  logic [uof_pkg::REP_W-1:0] repeat_q;
  logic                      q_valid, q_ready;
  uof_pkg::cmd_t             q_cmd;
  uof_pkg::status_e          status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repeat_q <= cfg_data_i;
    end
  end

  uof_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cmd_valid_o (q_valid),
    .cmd_ready_i (q_ready),
    .cmd_o       (q_cmd)
  );

  uof_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .repeat_i     (repeat_q),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_status_o (status),
    .out_eol_o    (m_axis_tlast)
  );

  assign m_axis_tuser = status;

  `UOF_ASSERT(a_eol_is_lf, !(m_axis_tvalid && m_axis_tlast) || (m_axis_tdata == uof_pkg::CH_NL && status == uof_pkg::ST_DATA), "end of line beat is not a data LF")
  `UOF_ASSERT(a_err_zero_byte, !(m_axis_tvalid && status != uof_pkg::ST_DATA) || (m_axis_tdata == 8'h00 && !m_axis_tlast), "status beat carries data")
  `UOF_ASSERT_NEXT(a_queue_holds, q_valid && !q_ready, q_valid, "queued command lost while stalled")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RUN_LIMIT  = 200000;
  localparam int unsigned BEAT_GOAL  = 1400;
  localparam int unsigned IDLE_PCT   = 22;

  typedef struct packed {
    logic       pull;
    logic [7:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       ch;
    uof_pkg::status_e st;
    logic             eol;
  } result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;  // [7:0] in_byte
  logic                      s_axis_tuser  = 1'b0;  // [0] req_type
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;  // [7:0] out_byte
  logic [1:0]                m_axis_tuser;  // [1:0] status
  logic                      m_axis_tlast;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [uof_pkg::REP_W-1:0] cfg_data_i    = '0;

  uppercase_overstrike_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt  = 0;
  int unsigned beat_count = 0;
  logic        calm;

  // no idling on either side inside this window
  assign calm = (cycle_cnt >= 300) && (cycle_cnt < 900);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- line printer model ----------------
  logic [6:0]                line_buf [uof_pkg::LINE_MAX];
  logic [uof_pkg::LEN_W-1:0] line_len   = '0;
  logic                      line_upper = 1'b0;
  logic                      emit_on    = 1'b0;
  logic [uof_pkg::REP_W-1:0] pass_cnt   = '0;
  logic [uof_pkg::LEN_W-1:0] emit_pos   = '0;
  logic                      err_sticky = 1'b0;
  logic [uof_pkg::REP_W-1:0] repeat_reg = '0;

  in_beat_t pending_beats [$];
  result_t  expected_out [$];

  function automatic logic cap_letter(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic int unsigned passes_now();
    return (repeat_reg > uof_pkg::MAX_REPEAT) ? uof_pkg::MAX_REPEAT : repeat_reg;
  endfunction

  // overprint pass: capitals and control codes stay, the rest blanks out
  function automatic logic [7:0] overstrike_char(input logic [6:0] c);
    if (cap_letter({1'b0, c}) || c < 7'h20 || c == 7'h7F) return {1'b0, c};
    return uof_pkg::CH_SP;
  endfunction

  function automatic void queue_answer(input logic [7:0] ch, input uof_pkg::status_e st,
                                       input logic eol);
    result_t r;
    r.ch  = ch;
    r.st  = st;
    r.eol = eol;
    expected_out.push_back(r);
  endfunction

  task automatic filter_step(input in_beat_t b);
    if (err_sticky) begin
      queue_answer(8'h00, uof_pkg::ST_NOT_ASCII, 1'b0);
    end else if (b.pull) begin
      if (emit_on) begin
        if (line_upper && pass_cnt < passes_now()) begin
          if (emit_pos < line_len) begin
            queue_answer(overstrike_char(line_buf[emit_pos]), uof_pkg::ST_DATA, 1'b0);
            emit_pos++;
          end else begin
            emit_pos = '0;
            pass_cnt++;
            queue_answer(uof_pkg::CH_CR, uof_pkg::ST_DATA, 1'b0);
          end
        end else if (emit_pos < line_len) begin
          queue_answer({1'b0, line_buf[emit_pos]}, uof_pkg::ST_DATA, 1'b0);
          emit_pos++;
        end else if (line_upper && emit_pos == line_len) begin
          emit_pos++;
          queue_answer(uof_pkg::CH_CR, uof_pkg::ST_DATA, 1'b0);
        end else begin
          emit_on    = 1'b0;
          line_len   = '0;
          line_upper = 1'b0;
          pass_cnt   = '0;
          emit_pos   = '0;
          queue_answer(uof_pkg::CH_NL, uof_pkg::ST_DATA, 1'b1);
        end
      end
    end else if (b.ch[7]) begin
      err_sticky = 1'b1;
      queue_answer(8'h00, uof_pkg::ST_NOT_ASCII, 1'b0);
    end else if (emit_on) begin
      queue_answer(8'h00, uof_pkg::ST_BUSY, 1'b0);
    end else if (b.ch == uof_pkg::CH_NL) begin
      emit_on  = 1'b1;
      pass_cnt = '0;
      emit_pos = '0;
    end else if (b.ch == uof_pkg::CH_FF) begin
      queue_answer(uof_pkg::CH_FF, uof_pkg::ST_DATA, 1'b0);
    end else if (line_len >= uof_pkg::LINE_MAX) begin
      queue_answer(8'h00, uof_pkg::ST_OVERFLOW, 1'b0);
    end else begin
      line_buf[line_len] = b.ch[6:0];
      line_len++;
      if (cap_letter(b.ch)) line_upper = 1'b1;
    end
  endtask

  // ---------------- driver ----------------
  in_beat_t cur_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) filter_step(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_beat.ch;
          s_axis_tuser  <= cur_beat.pull;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected beat byte %h status %0d last %b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_cnt++;
        end else begin
          want = expected_out.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $display("%0t: out_byte exp %h act %h", $time, want.ch, m_axis_tdata);
            fail_cnt++;
          end
          if (m_axis_tuser !== want.st) begin
            $display("%0t: status exp %0d act %0d", $time, want.st, m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tlast !== want.eol) begin
            $display("%0t: end_of_line exp %b act %b", $time, want.eol, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_push(input logic [7:0] ch);
    in_beat_t b;
    b.pull = 1'b0;
    b.ch   = ch;
    pending_beats.push_back(b);
    beat_count++;
  endtask

  // pull while idle: the block ignores it, so it is not counted
  task automatic add_idle_pull();
    in_beat_t b;
    b.pull = 1'b1;
    b.ch   = 8'($urandom_range(0, 255));
    pending_beats.push_back(b);
  endtask

  task automatic add_pull();
    add_idle_pull();
    beat_count++;
  endtask

  function automatic logic [7:0] rand_text(input bit allow_upper);
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 35) c = 8'h41 + 8'($urandom_range(0, 25));
    else if (r < 60) c = 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 80) c = 8'h20 + 8'($urandom_range(0, 94));
    else if (r < 92) begin
      c = 8'($urandom_range(0, 31));
      if (c == uof_pkg::CH_NL) c = 8'h0B;
    end else begin
      case ($urandom_range(0, 4))
        0: c = 8'h7F;
        1: c = 8'h40;
        2: c = 8'h5B;
        3: c = 8'h7E;
        default: c = uof_pkg::CH_SP;
      endcase
    end
    if (!allow_upper && cap_letter(c)) c = c | 8'h20;
    return c;
  endfunction

  // one line, its newline, and exactly enough pulls to drain it
  task automatic send_line(input int len, input bit allow_upper);
    int          stored;
    bit          got_upper;
    int unsigned drain;
    logic [7:0]  c;
    stored    = 0;
    got_upper = 1'b0;
    for (int i = 0; i < len; i++) begin
      c = rand_text(allow_upper);
      add_push(c);
      if (c != uof_pkg::CH_FF && stored < uof_pkg::LINE_MAX) begin
        stored++;
        if (cap_letter(c)) got_upper = 1'b1;
      end
    end
    add_push(uof_pkg::CH_NL);
    drain = got_upper ? passes_now() * (stored + 1) + stored + 2 : stored + 1;
    for (int k = 0; k < drain; k++) begin
      if ($urandom_range(0, 99) < 6) add_push(8'($urandom_range(0, 127)));
      add_pull();
    end
    if ($urandom_range(0, 99) < 30) add_idle_pull();
  endtask

  // sampled at the falling edge, after the driver has settled its beat
  task automatic settle();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_out.size() != 0)
      @(negedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [uof_pkg::REP_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    repeat_reg = v;
  endtask

  initial begin
    int unsigned line_no;
    int unsigned r;
    int          len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: repeat count at reset value
    add_idle_pull();
    add_push(uof_pkg::CH_FF);
    add_push(8'h00);
    add_push(8'h5A);
    add_push(8'h7F);
    add_push(uof_pkg::CH_NL);
    add_pull();
    add_pull();
    add_push(8'h71);  // busy
    add_pull();
    add_pull();
    add_pull();
    add_idle_pull();
    settle();

    cfg_write(4'd1);
    add_push(8'h41);
    add_push(8'h40);
    add_push(8'h5B);
    add_push(uof_pkg::CH_NL);
    repeat (9) add_pull();
    add_push(uof_pkg::CH_NL);  // empty line
    add_pull();
    settle();

    // line longer than the store: fills it, then overflows (form feeds only by chance)
    cfg_write(4'd0);
    send_line(uof_pkg::LINE_MAX + 3, 1'b1);

    line_no = 0;
    while (beat_count < BEAT_GOAL) begin
      if (line_no < 3 || $urandom_range(0, 99) < 35) begin
        settle();
        case (line_no)
          0: cfg_write(4'd15);
          1: cfg_write(uof_pkg::REP_W'(uof_pkg::MAX_REPEAT));
          2: cfg_write(4'd10);
          default:
            if ($urandom_range(0, 99) < 60) cfg_write(4'($urandom_range(0, 3)));
            else cfg_write(4'($urandom_range(0, 15)));
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 12);
      else if (r < 95) len = $urandom_range(13, 60);
      else len = $urandom_range(61, 200);
      if (len > 60 && passes_now() > 2) len = $urandom_range(13, 60);
      if ($urandom_range(0, 9) == 0) add_idle_pull();
      send_line(len, $urandom_range(0, 99) >= 30);
      line_no++;
    end
    settle();

    // non-ASCII latches the error for the rest of the run
    add_push(8'h6B);
    add_push(8'h80);
    add_pull();
    add_push(8'h41);
    add_push(8'hFF);
    add_push(uof_pkg::CH_NL);
    add_pull();
    repeat (10) begin
      if ($urandom_range(0, 1) == 0) add_pull();
      else add_push(8'($urandom_range(0, 255)));
    end
    settle();

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/uof_pkg.sv
design/uof_front.sv
design/uof_back.sv
design/uppercase_overstrike_filter.sv
tb/sv/tb.sv
